[src/assert_macros.svh]
// assertion helpers used by the sequencer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define VRD_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define VRD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[src/vrd_pkg.sv]
// ----------------------------------------------------------------------------
// vrd_pkg
// types and constants of the valve relay drive sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package vrd_pkg;

   localparam int unsigned TRAVEL_WIDTH = 11;
   localparam int unsigned SLOT_WIDTH   = 7;
   localparam int unsigned BAND_WIDTH   = 15;
   localparam int unsigned DATA_WIDTH   = 16;

   localparam logic [TRAVEL_WIDTH-1:0] FULL_TRAVEL_TICKS = TRAVEL_WIDTH'(1200);
   localparam logic [TRAVEL_WIDTH-1:0] TRAVEL_RESET      = FULL_TRAVEL_TICKS >> 1;
   localparam logic [SLOT_WIDTH-1:0]   SLOT_PERIOD_MAX   = SLOT_WIDTH'(100);

   // drive state, one-hot
   typedef enum logic [4:0] {
      MODE_OFF       = 5'b00001,
      MODE_CLOSE_ON  = 5'b00010,
      MODE_CLOSE_OFF = 5'b00100,
      MODE_OPEN_ON   = 5'b01000,
      MODE_OPEN_OFF  = 5'b10000
   } drive_mode_type;

   // reported motion codes
   localparam logic [1:0] MOTION_STOPPED = 2'd0;
   localparam logic [1:0] MOTION_CLOSING = 2'd1;
   localparam logic [1:0] MOTION_OPENING = 2'd2;

   typedef struct packed {
      logic                    relay_close;
      logic                    relay_open;
      logic                    close_indicator;
      logic                    open_indicator;
      logic                    activity_led;
      logic [1:0]              motion;
      logic [TRAVEL_WIDTH-1:0] position_estimate;
   } result_type;

endpackage

`default_nettype wire

[src/valve_relay_drive_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// valve_relay_drive_sequencer_unit
// time-proportional relay drive for a motorised mixing valve
// ----------------------------------------------------------------------------
// usage
//  - req_* channel: one request per control tick (enable, temperature error,
//    control value, hall switch); valid/ready handshake
//  - rsp_* channel: exactly one response per request, in order, carrying the
//    relay and indicator levels, led level, motion code and position estimate
//  - csr_* channel: writes the hysteresis band; always ready, write only while
//    no request is in flight
//  - the response is registered, via the skid entry while the result is held;
//    one request per cycle while req_ready is high (single state update stage)
//  - a two-entry output buffer (result register plus skid register) lets a
//    request be taken while a finished response waits; req_ready drops only
//    when both entries hold a response
//  - reset: slot counter 0, drive off, close relay high, led high, position at
//    half travel, band 0, output buffer empty
//  - a disabled request changes no state and reports the held levels
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module valve_relay_drive_sequencer_unit
   import vrd_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [BAND_WIDTH-1:0]          csr_hysteresis_band,
   // requests
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_enable,
   input  wire logic signed [DATA_WIDTH-1:0]   req_temp_error,
   input  wire logic signed [DATA_WIDTH-1:0]   req_control_value,
   input  wire logic                           req_hall_below_half,
   // responses
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_relay_close,
   output logic                                rsp_relay_open,
   output logic                                rsp_close_indicator,
   output logic                                rsp_open_indicator,
   output logic                                rsp_activity_led,
   output logic [1:0]                          rsp_motion,
   output logic [TRAVEL_WIDTH-1:0]             rsp_position_estimate
);

   // configuration register
   logic [BAND_WIDTH-1:0] band_ff;

   // control state
   logic [SLOT_WIDTH-1:0]   slot_ff, slot_in;
   drive_mode_type          mode_ff, mode_in;
   drive_mode_type          prev_mode_ff;
   logic [TRAVEL_WIDTH-1:0] travel_ff, travel_in;
   logic                    blink_ff, blink_in;
   logic                    relay_close_ff, relay_close_in;
   logic                    relay_open_ff, relay_open_in;
   logic                    ind_close_ff, ind_close_in;
   logic                    ind_open_ff, ind_open_in;
   logic                    led_ff, led_in;

   // output buffer
   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;
   result_type result_in;

   logic req_fire, rsp_fire;

   // signed working values, one bit wider than the fields
   logic signed [DATA_WIDTH:0] err_ext, cv_ext, cv_neg, band_ext, slot_ext;
   logic                       outside_band;
   logic                       want_close, want_open;
   logic                       go_close, go_open;
   logic [1:0]                 motion_code;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
      end else if (csr_valid) begin
         band_ff <= csr_hysteresis_band;
      end
   end

   // slot counter wraps after the period maximum
   always_comb begin
      if (slot_ff < SLOT_PERIOD_MAX) begin
         slot_in = slot_ff + SLOT_WIDTH'(1);
      end else begin
         slot_in = '0;
      end
   end

   always_comb begin
      err_ext      = {req_temp_error[DATA_WIDTH-1], req_temp_error};
      cv_ext       = {req_control_value[DATA_WIDTH-1], req_control_value};
      cv_neg       = -cv_ext;
      band_ext     = $signed({2'b00, band_ff});
      slot_ext     = $signed({(DATA_WIDTH + 1 - SLOT_WIDTH)'(0), slot_in});
      outside_band = (err_ext > band_ext) || (err_ext < -band_ext);

      // duty request in each direction; a zero control value counts as opening
      want_close = outside_band && req_control_value[DATA_WIDTH-1] && (cv_neg > slot_ext);
      want_open  = outside_band && !req_control_value[DATA_WIDTH-1] && (cv_ext > slot_ext);

      // reversal gives one dead tick, and the travel ends stop the drive
      go_close = want_close && (mode_ff != MODE_OPEN_ON) && (travel_ff != '0);
      go_open  = want_open && (mode_ff != MODE_CLOSE_ON) && (travel_ff < FULL_TRAVEL_TICKS);
   end

   always_comb begin
      mode_in        = mode_ff;
      travel_in      = travel_ff;
      blink_in       = blink_ff;
      led_in         = led_ff;
      relay_close_in = relay_close_ff;
      relay_open_in  = relay_open_ff;
      ind_close_in   = ind_close_ff;
      ind_open_in    = ind_open_ff;

      if (req_enable) begin
         priority if (go_close) begin
            mode_in   = MODE_CLOSE_ON;
            travel_in = travel_ff - TRAVEL_WIDTH'(1);
         end else if (go_open) begin
            mode_in   = MODE_OPEN_ON;
            travel_in = travel_ff + TRAVEL_WIDTH'(1);
         end else begin
            mode_in = MODE_OFF;
         end

         // led toggles while moving, low when stopped
         if (go_close || go_open) begin
            led_in   = blink_ff;
            blink_in = !blink_ff;
         end else begin
            led_in = 1'b0;
         end

         // relays follow only a change of drive state
         if (prev_mode_ff != mode_in) begin
            relay_close_in = 1'b0;
            relay_open_in  = 1'b0;
            ind_close_in   = 1'b0;
            ind_open_in    = 1'b0;
            if (mode_in == MODE_CLOSE_ON) begin
               relay_close_in = 1'b1;
               ind_close_in   = 1'b1;
            end else if (mode_in == MODE_OPEN_ON) begin
               relay_open_in = req_hall_below_half;
               ind_open_in   = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (mode_in == MODE_CLOSE_ON) begin
         motion_code = MOTION_CLOSING;
      end else if (mode_in == MODE_OPEN_ON) begin
         motion_code = MOTION_OPENING;
      end else begin
         motion_code = MOTION_STOPPED;
      end
      result_in.relay_close       = relay_close_in;
      result_in.relay_open        = relay_open_in;
      result_in.close_indicator   = ind_close_in;
      result_in.open_indicator    = ind_open_in;
      result_in.activity_led      = led_in;
      result_in.motion            = motion_code;
      result_in.position_estimate = travel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff        <= '0;
         mode_ff        <= MODE_OFF;
         prev_mode_ff   <= MODE_CLOSE_OFF;
         travel_ff      <= TRAVEL_RESET;
         blink_ff       <= 1'b1;
         relay_close_ff <= 1'b1;
         relay_open_ff  <= 1'b0;
         ind_close_ff   <= 1'b0;
         ind_open_ff    <= 1'b0;
         led_ff         <= 1'b1;
      end else if (req_fire && req_enable) begin
         slot_ff        <= slot_in;
         mode_ff        <= mode_in;
         prev_mode_ff   <= mode_in;
         travel_ff      <= travel_in;
         blink_ff       <= blink_in;
         relay_close_ff <= relay_close_in;
         relay_open_ff  <= relay_open_in;
         ind_close_ff   <= ind_close_in;
         ind_open_ff    <= ind_open_in;
         led_ff         <= led_in;
      end
   end

   // output register with skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_fire;
         end
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (req_fire) begin
            out_data_ff <= result_in;
         end
      end else if (req_fire) begin
         skid_data_ff <= result_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_relay_close       = out_data_ff.relay_close;
   assign rsp_relay_open        = out_data_ff.relay_open;
   assign rsp_close_indicator   = out_data_ff.close_indicator;
   assign rsp_open_indicator    = out_data_ff.open_indicator;
   assign rsp_activity_led      = out_data_ff.activity_led;
   assign rsp_motion            = out_data_ff.motion;
   assign rsp_position_estimate = out_data_ff.position_estimate;

   // checks
   `VRD_ASSERT_IMPLY(a_relays_exclusive, clock, reset, 1'b1,
      !(relay_close_ff && relay_open_ff), "both relays driven")
   `VRD_ASSERT_IMPLY(a_travel_in_range, clock, reset, 1'b1,
      travel_ff <= FULL_TRAVEL_TICKS, "travel count beyond full travel")
   `VRD_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff,
      out_valid_ff, "skid entry held with empty result register")
   `VRD_ASSERT_NEXT(a_close_counts_down, clock, reset,
      req_fire && req_enable && go_close,
      travel_ff == $past(travel_ff) - TRAVEL_WIDTH'(1), "closing tick did not count down")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the valve relay drive sequencer
// ----------------------------------------------------------------------------
// every accepted request is run through a behavioural copy of the tick logic
// and the predicted response is queued; each response taken from the block is
// checked field by field against the oldest prediction. the stimulus walks
// the hysteresis band edges, direction reversals and hall gating, then sweeps
// the valve to both travel stops and finishes with mixed random traffic
// under several band settings. both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import vrd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // stall styles of the response side
   typedef enum logic [1:0] {
      SINK_ALWAYS,
      SINK_COIN,
      SINK_SPARSE,
      SINK_PERIODIC
   } sink_style_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [BAND_WIDTH-1:0]          csr_hysteresis_band = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_enable = 1'b0;
   logic signed [DATA_WIDTH-1:0]   req_temp_error = '0;
   logic signed [DATA_WIDTH-1:0]   req_control_value = '0;
   logic                           req_hall_below_half = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_relay_close;
   logic                           rsp_relay_open;
   logic                           rsp_close_indicator;
   logic                           rsp_open_indicator;
   logic                           rsp_activity_led;
   logic [1:0]                     rsp_motion;
   logic [TRAVEL_WIDTH-1:0]        rsp_position_estimate;

   valve_relay_drive_sequencer_unit DUT (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_hysteresis_band   (csr_hysteresis_band),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_enable            (req_enable),
      .req_temp_error        (req_temp_error),
      .req_control_value     (req_control_value),
      .req_hall_below_half   (req_hall_below_half),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_relay_close       (rsp_relay_close),
      .rsp_relay_open        (rsp_relay_open),
      .rsp_close_indicator   (rsp_close_indicator),
      .rsp_open_indicator    (rsp_open_indicator),
      .rsp_activity_led      (rsp_activity_led),
      .rsp_motion            (rsp_motion),
      .rsp_position_estimate (rsp_position_estimate)
   );

   // 4 time unit period
   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor state, a private copy of what the block holds
   // ---------------------------------------------------------------------
   logic [BAND_WIDTH-1:0]   band_setting;
   logic [SLOT_WIDTH-1:0]   slot_count;
   drive_mode_type          drive_state;
   drive_mode_type          last_state;
   logic [TRAVEL_WIDTH-1:0] travel_count;
   logic                    blink;
   logic                    led;
   logic                    close_level;
   logic                    open_level;
   logic                    close_lamp;
   logic                    open_lamp;

   result_type expected_drive[$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         burst_left = 0;
   int         sink_left = 0;
   sink_style_type sink_style = SINK_ALWAYS;

   function automatic void reset_drive_model();
      band_setting = '0;
      slot_count   = '0;
      drive_state  = MODE_OFF;
      last_state   = MODE_CLOSE_OFF;
      travel_count = TRAVEL_RESET;
      blink        = 1'b1;
      led          = 1'b1;
      close_level  = 1'b1;
      open_level   = 1'b0;
      close_lamp   = 1'b0;
      open_lamp    = 1'b0;
   endfunction

   // one control tick: updates the copied state and returns the response
   function automatic result_type advance_drive(logic en, logic signed [15:0] err,
                                                logic signed [15:0] cv, logic hall);
      int         e;
      int         c;
      int         b;
      logic       moving;
      result_type r;
      e = err;
      c = cv;
      b = int'(band_setting);
      moving = 1'b0;
      if (en) begin
         if (slot_count < SLOT_PERIOD_MAX) slot_count = slot_count + 1'b1;
         else slot_count = '0;

         // outside the dead band the sign of the control value picks the
         // direction and its size sets the on-time within the slot period
         if (e > b || e < -b) begin
            if (c < 0) begin
               if (-c > int'(slot_count)) begin
                  if (drive_state == MODE_OPEN_ON) drive_state = MODE_OPEN_OFF;
                  else drive_state = MODE_CLOSE_ON;
               end else begin
                  drive_state = MODE_CLOSE_OFF;
               end
            end else begin
               if (c > int'(slot_count)) begin
                  if (drive_state == MODE_CLOSE_ON) drive_state = MODE_CLOSE_OFF;
                  else drive_state = MODE_OPEN_ON;
               end else begin
                  drive_state = MODE_OPEN_OFF;
               end
            end
         end else begin
            drive_state = MODE_OFF;
         end

         // travel stops at either end
         if (travel_count > 0 && drive_state == MODE_CLOSE_ON) begin
            travel_count = travel_count - 1'b1;
            moving = 1'b1;
         end
         if (travel_count < FULL_TRAVEL_TICKS && drive_state == MODE_OPEN_ON) begin
            travel_count = travel_count + 1'b1;
            moving = 1'b1;
         end
         if (!moving) begin
            drive_state = MODE_OFF;
            led = 1'b0;
         end else begin
            led = blink;
            blink = !blink;
         end

         // relays only move on a change of drive state
         if (last_state != drive_state) begin
            if (drive_state == MODE_CLOSE_ON) begin
               open_level = 1'b0;
               open_lamp = 1'b0;
               close_level = 1'b1;
               close_lamp = 1'b1;
            end else if (drive_state == MODE_OPEN_ON) begin
               open_level = hall;
               open_lamp = 1'b1;
               close_level = 1'b0;
               close_lamp = 1'b0;
            end else begin
               open_level = 1'b0;
               open_lamp = 1'b0;
               close_level = 1'b0;
               close_lamp = 1'b0;
            end
         end
         last_state = drive_state;
      end

      r.relay_close       = close_level;
      r.relay_open        = open_level;
      r.close_indicator   = close_lamp;
      r.open_indicator    = open_lamp;
      r.activity_led      = led;
      if (drive_state == MODE_CLOSE_ON) r.motion = MOTION_CLOSING;
      else if (drive_state == MODE_OPEN_ON) r.motion = MOTION_OPENING;
      else r.motion = MOTION_STOPPED;
      r.position_estimate = travel_count;
      return r;
   endfunction

   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // monitor: checks responses, tracks band writes, predicts each request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      result_type seen;
      result_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         reset_drive_model();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_relay_close, rsp_relay_open, rsp_close_indicator,
                    rsp_open_indicator, rsp_activity_led, rsp_motion,
                    rsp_position_estimate};
            if (expected_drive.size() == 0) begin
               $error("response with no request waiting");
               error_count++;
            end else begin
               want = expected_drive.pop_front();
               compare_field("relay_close", want.relay_close, seen.relay_close);
               compare_field("relay_open", want.relay_open, seen.relay_open);
               compare_field("close_indicator", want.close_indicator,
                             seen.close_indicator);
               compare_field("open_indicator", want.open_indicator,
                             seen.open_indicator);
               compare_field("activity_led", want.activity_led, seen.activity_led);
               compare_field("motion", want.motion, seen.motion);
               compare_field("position_estimate", want.position_estimate,
                             seen.position_estimate);
            end
         end
         // the band is only written while no request is in flight
         if (csr_valid && csr_ready) band_setting = csr_hysteresis_band;
         if (req_valid && req_ready)
            expected_drive.push_back(advance_drive(req_enable, req_temp_error,
                                                   req_control_value,
                                                   req_hall_below_half));
      end
   end

   // response side stalls, with a stall style picked at random for each stretch
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_style = sink_style_type'($urandom_range(0, 3));
         sink_left = $urandom_range(20, 200);
      end
      sink_left--;
      case (sink_style)
         SINK_ALWAYS: rsp_ready <= 1'b1;
         SINK_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((sink_left % 5) >= 2);
      endcase
   end

   // ---------------------------------------------------------------------
   // shared drivers
   // ---------------------------------------------------------------------

   // one request; bursts of random length with idle gaps between them
   task automatic send_tick(logic en, logic signed [15:0] err,
                            logic signed [15:0] cv, logic hall);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_valid           <= 1'b1;
      req_enable          <= en;
      req_temp_error      <= err;
      req_control_value   <= cv;
      req_hall_below_half <= hall;
      do @(posedge clock); while (!req_ready);
   endtask

   // lets every outstanding response drain, plus a little latency margin
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drive.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_band(logic [BAND_WIDTH-1:0] value);
      drain();
      @(negedge clock);
      csr_valid           <= 1'b1;
      csr_hysteresis_band <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // error near or far from the band, either sign
   function automatic logic signed [15:0] pick_error(int b);
      int v;
      case ($urandom_range(0, 4))
         0: v = $urandom_range(0, 65535);
         1: v = $urandom_range(0, 1) ? b : -b;
         2: v = $urandom_range(0, 1) ? b + 1 : -b - 1;
         3: v = int'($urandom_range(0, 2 * b + 2)) - b - 1;
         default: v = int'($urandom_range(0, 40)) - 20;
      endcase
      return 16'(v);
   endfunction

   // error that always lies outside a zero band
   function automatic logic signed [15:0] nonzero_error();
      int m;
      m = $urandom_range(1, 32768);
      return 16'($urandom_range(0, 1) ? m : -m);
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // held reset levels on a disabled tick, then a tick inside a zero band
   task automatic test_reset_levels();
      send_tick(1'b0, 16'sd0, 16'sd0, 1'b0);
      send_tick(1'b1, 16'sd0, 16'sd500, 1'b1);
      send_tick(1'b0, 16'sd100, 16'sd100, 1'b1);
   endtask

   // errors exactly on and just past the band edge, and the 16-bit extremes
   task automatic test_band_edges();
      write_band(15'd16);
      send_tick(1'b1, 16'sd16, 16'sd50, 1'b1);
      send_tick(1'b1, -16'sd16, 16'sd50, 1'b1);
      send_tick(1'b1, 16'sd17, 16'sd50, 1'b1);
      send_tick(1'b1, -16'sd17, -16'sd50, 1'b1);
      write_band(15'h7fff);
      send_tick(1'b1, 16'sh7fff, 16'sh8000, 1'b0);
      send_tick(1'b1, 16'sh8000, 16'sh8000, 1'b0);
   endtask

   // dead time on reversal, zero control value, hall gating, small duty
   task automatic test_direction_changes();
      write_band(15'd0);
      send_tick(1'b1, 16'sd100, 16'sh7fff, 1'b1);
      send_tick(1'b1, 16'sd100, 16'sh7fff, 1'b1);
      send_tick(1'b1, 16'sd100, 16'sh7fff, 1'b0);
      send_tick(1'b1, -16'sd5, 16'sd0, 1'b1);
      send_tick(1'b1, 16'sd5, 16'sh7fff, 1'b0);
      send_tick(1'b1, 16'sd5, -16'sd1, 1'b1);
      send_tick(1'b1, 16'sd5, -16'sd1, 1'b1);
      send_tick(1'b1, 16'sd5, 16'sd1, 1'b1);
      send_tick(1'b1, 16'sd1, 16'sh8000, 1'b1);
      send_tick(1'b1, -16'sd1, -16'sh7fff, 1'b1);
   endtask

   // full-duty runs long enough to hit the closed stop, then the open stop
   task automatic test_end_of_travel();
      int m;
      write_band(15'd0);
      repeat (630) begin
         m = $urandom_range(101, 32768);
         send_tick(($urandom_range(0, 63) != 0), nonzero_error(), 16'(-m),
                   1'($urandom_range(0, 1)));
      end
      repeat (1240) begin
         m = $urandom_range(101, 32767);
         send_tick(($urandom_range(0, 63) != 0), nonzero_error(), 16'(m),
                   ($urandom_range(0, 7) != 0));
      end
   endtask

   // direction runs with random duty, noise and disabled ticks per band
   task automatic test_random_traffic();
      int   bands[5];
      int   run_left;
      int   run_sign;
      int   cv;
      logic hall;
      bands[0] = 32767;
      bands[1] = 1;
      bands[2] = $urandom_range(0, 200);
      bands[3] = $urandom_range(0, 32767);
      bands[4] = 40;
      run_left = 0;
      run_sign = 1;
      hall = 1'b1;
      foreach (bands[p]) begin
         write_band(15'(bands[p]));
         repeat (20) begin
            if (run_left == 0) begin
               run_left = $urandom_range(10, 80);
               run_sign = $urandom_range(0, 1) ? 1 : -1;
            end
            run_left--;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: cv = run_sign * int'($urandom_range(1, 120));
               6, 7: cv = run_sign * int'($urandom_range(121, 32767));
               8: cv = 0;
               default: cv = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 9) == 0) hall = !hall;
            send_tick(($urandom_range(0, 9) != 0), pick_error(bands[p]), 16'(cv), hall);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_levels();
      test_band_edges();
      test_direction_changes();
      test_end_of_travel();
      test_random_traffic();

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_drive.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // hang guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb_top: errors");
      $finish;
   end

endmodule
